[rtl/eie_pkg.sv]
// shared types and constants of the ebpf instruction execute unit
package eie_pkg;

  // register file
  localparam int unsigned NUM_REGS = 11;
  localparam logic [3:0] MAX_REG = 4'd10;
  localparam logic [3:0] REG_RET = 4'd0;
  localparam logic [3:0] REG_ARG = 4'd1;
  localparam logic [3:0] REG_FP = 4'd10;

  // program counter and decoupling queue
  localparam int unsigned PC_W = 12;
  localparam int unsigned QUEUE_DEPTH = 4;

  // stack size in bytes, a power of two so that addresses wrap by truncation
  localparam int unsigned STACK_BYTES = 512;

  localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

  // configuration register address
  localparam logic [3:0] ADDR_INITIAL_ARG = 4'h0;

  // instruction classes
  localparam logic [2:0] CLS_LD = 3'd0;
  localparam logic [2:0] CLS_LDX = 3'd1;
  localparam logic [2:0] CLS_ST = 3'd2;
  localparam logic [2:0] CLS_STX = 3'd3;
  localparam logic [2:0] CLS_ALU = 3'd4;
  localparam logic [2:0] CLS_JMP = 3'd5;
  localparam logic [2:0] CLS_JMP32 = 3'd6;
  localparam logic [2:0] CLS_ALU64 = 3'd7;

  // memory mode and access size codes
  localparam logic [2:0] MODE_MEM = 3'b011;
  localparam logic [1:0] SZ_W = 2'd0;
  localparam logic [1:0] SZ_H = 2'd1;
  localparam logic [1:0] SZ_B = 2'd2;
  localparam logic [1:0] SZ_DW = 2'd3;

  // alu operation codes
  localparam logic [3:0] AOP_ADD = 4'h0;
  localparam logic [3:0] AOP_SUB = 4'h1;
  localparam logic [3:0] AOP_MUL = 4'h2;
  localparam logic [3:0] AOP_LSH = 4'h6;
  localparam logic [3:0] AOP_MOV = 4'hB;
  localparam logic [3:0] AOP_ARSH = 4'hC;

  // jump operation codes
  localparam logic [3:0] JOP_JA = 4'h0;
  localparam logic [3:0] JOP_JEQ = 4'h1;
  localparam logic [3:0] JOP_JGT = 4'h2;
  localparam logic [3:0] JOP_JGE = 4'h3;
  localparam logic [3:0] JOP_JSET = 4'h4;
  localparam logic [3:0] JOP_JNE = 4'h5;
  localparam logic [3:0] JOP_CALL = 4'h8;
  localparam logic [3:0] JOP_EXIT = 4'h9;

  typedef enum logic [1:0] {
    ST_CONTINUE,
    ST_EXIT,
    ST_HELPER,
    ST_ERROR
  } status_e;

  typedef enum logic [3:0] {
    K_START,
    K_ERR,
    K_LDX,
    K_ST,
    K_STX,
    K_ALU,
    K_JMP,
    K_CALL,
    K_EXIT
  } kind_e;

  typedef enum logic [2:0] {
    A_ADD,
    A_SUB,
    A_MUL,
    A_LSH,
    A_MOV,
    A_ARSH
  } alu_e;

  typedef enum logic [2:0] {
    J_JA,
    J_JEQ,
    J_JGT,
    J_JGE,
    J_JSET,
    J_JNE
  } jcc_e;

  typedef enum logic [1:0] {
    EX_RUN,
    EX_LOAD,
    EX_MUL
  } ex_state_e;

  // classified instruction as it travels through the queue
  typedef struct packed {
    kind_e       kind;
    alu_e        alu;
    jcc_e        jcc;
    logic        w64;
    logic        use_src;
    logic [1:0]  size_log;
    logic [3:0]  di;
    logic [3:0]  si;
    logic [15:0] offset;
    logic [31:0] imm;
    logic [63:0] call_return;
  } item_t;

  // one result transaction
  typedef struct packed {
    status_e         status;
    logic [PC_W-1:0] next_pc;
    logic [63:0]     dst_value;
    logic [63:0]     ret_value;
    logic [7:0]      helper_id;
  } result_t;

endpackage

[rtl/eie_front.sv]
// front end: classifies each incoming instruction transaction
module eie_front import eie_pkg::*; (
  input  logic        cmd_i,
  input  logic [7:0]  opcode_i,
  input  logic [3:0]  dst_index_i,
  input  logic [3:0]  src_index_i,
  input  logic [15:0] offset_i,
  input  logic [31:0] imm_i,
  input  logic [63:0] call_return_i,
  output item_t       item_o
);

  logic [2:0] cls;
  logic [3:0] op_hi;

  assign cls = opcode_i[2:0];
  assign op_hi = opcode_i[7:4];

  // decode class, operation and access size
  always_comb begin
    item_o = '0;
    item_o.kind = K_ERR;
    item_o.alu = A_ADD;
    item_o.jcc = J_JA;
    item_o.w64 = 1'b0;
    item_o.use_src = opcode_i[3];
    item_o.di = dst_index_i;
    item_o.si = src_index_i;
    item_o.offset = offset_i;
    item_o.imm = imm_i;
    item_o.call_return = call_return_i;

    unique case (opcode_i[4:3])
      SZ_W:    item_o.size_log = 2'd2;
      SZ_H:    item_o.size_log = 2'd1;
      SZ_B:    item_o.size_log = 2'd0;
      default: item_o.size_log = 2'd3;
    endcase

    priority if (!cmd_i) begin
      item_o.kind = K_START;
    end else if (dst_index_i > MAX_REG || src_index_i > MAX_REG) begin
      item_o.kind = K_ERR;
    end else begin
      unique case (cls)
        CLS_LDX, CLS_ST, CLS_STX: begin
          if (opcode_i[7:5] == MODE_MEM) begin
            if (cls == CLS_LDX) item_o.kind = K_LDX;
            else if (cls == CLS_ST) item_o.kind = K_ST;
            else item_o.kind = K_STX;
          end
        end
        CLS_ALU, CLS_ALU64: begin
          item_o.w64 = (cls == CLS_ALU64);
          item_o.kind = K_ALU;
          unique case (op_hi)
            AOP_ADD:  item_o.alu = A_ADD;
            AOP_SUB:  item_o.alu = A_SUB;
            AOP_MUL:  item_o.alu = A_MUL;
            AOP_LSH:  item_o.alu = A_LSH;
            AOP_MOV:  item_o.alu = A_MOV;
            AOP_ARSH: item_o.alu = A_ARSH;
            default:  item_o.kind = K_ERR;
          endcase
        end
        CLS_JMP, CLS_JMP32: begin
          item_o.w64 = (cls == CLS_JMP);
          item_o.kind = K_JMP;
          unique case (op_hi)
            JOP_JA:   item_o.jcc = J_JA;
            JOP_JEQ:  item_o.jcc = J_JEQ;
            JOP_JGT:  item_o.jcc = J_JGT;
            JOP_JGE:  item_o.jcc = J_JGE;
            JOP_JSET: item_o.jcc = J_JSET;
            JOP_JNE:  item_o.jcc = J_JNE;
            JOP_CALL: item_o.kind = K_CALL;
            JOP_EXIT: item_o.kind = K_EXIT;
            default:  item_o.kind = K_ERR;
          endcase
        end
        default: item_o.kind = K_ERR;
      endcase
    end
  end

endmodule

[rtl/eie_queue.sv]
// short queue between the front end and the execute back end
module eie_queue import eie_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  item_t            entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push;

  assign full_o = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (pop_i) rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_push && !pop_i) count_d = count_q + 1'b1;
    else if (!do_push && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count missed a push");

endmodule

[rtl/eie_back.sv]
// back end: register read, execute, stack access and result register
module eie_back import eie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  item_t       head_i,
  output logic        pop_o,
  input  logic [63:0] initial_arg_i,
  output logic        out_valid_o,
  output result_t     result_o,
  input  logic        out_pop_i
);

  localparam int unsigned ADDR_W = $clog2(STACK_BYTES);
  localparam int unsigned ROWS = STACK_BYTES / 8;
  localparam int unsigned ROW_W = ADDR_W - 3;
  localparam logic [63:0] STACK_VALUE = 64'(STACK_BYTES);

  // value a register holds right after reset
  function automatic logic [63:0] reg_reset_value(input logic [3:0] idx);
    return (idx == REG_FP) ? STACK_VALUE : 64'd0;
  endfunction

  // newest value of a register given this cycle's write
  function automatic logic [63:0] fwd_value(input logic [3:0] idx, input logic [63:0] cur,
                                             input logic start, input logic we,
                                             input logic [3:0] wa, input logic [63:0] wd,
                                             input logic [63:0] arg);
    logic [63:0] v;
    if (start) v = (idx == REG_ARG) ? arg : reg_reset_value(idx);
    else if (we && wa == idx) v = wd;
    else v = cur;
    return v;
  endfunction

  // register file storage
  logic [63:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid_q;
  logic                rf_we;
  logic [3:0]          rf_wa;
  logic [63:0]         rf_wd;
  logic                start_commit;
  logic [63:0]         r0_q;

  // read stage
  logic        rd_valid_q;
  item_t       rd_item_q;
  logic [63:0] rd_d_q, rd_s_q;
  logic        rd_advance;

  // execute stage
  logic            ex_valid_q;
  item_t           ex_item_q;
  logic [63:0]     ex_d_q, ex_s_q;
  ex_state_e       state_q, state_d;
  logic [1:0]      mul_cnt_q;
  logic [63:0]     acc_q, acc_d;
  logic            halted_q, halted_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            ex_done, ex_take, fin, go_load, go_mul;
  logic            wb_req, start_req, st_req, ld_issue, st_we;

  // operands and datapath
  logic [63:0]     d_op, s_raw, s_op, alu_res, ld_val, st_data, prod, wb_val;
  logic [5:0]      sh;
  logic            take;
  logic [3:0]      wb_idx;
  logic [63:0]     addr_base;
  logic [ADDR_W-1:0] mem_addr;
  logic [2:0]      ld_lo_q;
  logic [7:0]      bank_rdata_q [8];
  logic [31:0]     mul_x, mul_y;
  logic [PC_W-1:0] pc_inc, pc_tgt;
  logic [3:0]      nbytes;

  // result register
  logic    out_valid_q;
  result_t out_q, res;
  logic    out_free;

  assign out_free = !out_valid_q || out_pop_i;
  assign out_valid_o = out_valid_q;
  assign result_o = out_q;

  // stage hand-over
  assign ex_take = !ex_valid_q || ex_done;
  assign rd_advance = rd_valid_q && ex_take;
  assign pop_o = head_valid_i && (!rd_valid_q || rd_advance);

  // register file write and valid bits
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      r0_q <= '0;
    end else if (start_commit) begin
      rf_valid_q <= NUM_REGS'(1) << REG_ARG;
      r0_q <= '0;
    end else if (rf_we) begin
      rf_valid_q[rf_wa] <= 1'b1;
      if (rf_wa == REG_RET) r0_q <= rf_wd;
    end
  end

  // operand read with bypass of the write in flight
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_item_q <= head_i;
      rd_d_q <= fwd_value(head_i.di,
                          (head_i.di <= MAX_REG && rf_valid_q[head_i.di]) ?
                            rf_mem[head_i.di] : reg_reset_value(head_i.di),
                          start_commit, rf_we, rf_wa, rf_wd, initial_arg_i);
      rd_s_q <= fwd_value(head_i.si,
                          (head_i.si <= MAX_REG && rf_valid_q[head_i.si]) ?
                            rf_mem[head_i.si] : reg_reset_value(head_i.si),
                          start_commit, rf_we, rf_wa, rf_wd, initial_arg_i);
    end else begin
      rd_d_q <= fwd_value(rd_item_q.di, rd_d_q, start_commit, rf_we, rf_wa, rf_wd,
                          initial_arg_i);
      rd_s_q <= fwd_value(rd_item_q.si, rd_s_q, start_commit, rf_we, rf_wa, rf_wd,
                          initial_arg_i);
    end
    if (rd_advance) begin
      ex_item_q <= rd_item_q;
      ex_d_q <= fwd_value(rd_item_q.di, rd_d_q, start_commit, rf_we, rf_wa, rf_wd,
                          initial_arg_i);
      ex_s_q <= fwd_value(rd_item_q.si, rd_s_q, start_commit, rf_we, rf_wa, rf_wd,
                          initial_arg_i);
    end
    acc_q <= acc_d;
    if (ld_issue) ld_lo_q <= mem_addr[2:0];
    if (ex_done) out_q <= res;
  end

  // stage valid flags and architectural control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      ex_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= EX_RUN;
      mul_cnt_q <= '0;
      halted_q <= 1'b0;
      pc_q <= '0;
    end else begin
      if (pop_o) rd_valid_q <= 1'b1;
      else if (rd_advance) rd_valid_q <= 1'b0;
      if (rd_advance) ex_valid_q <= 1'b1;
      else if (ex_done) ex_valid_q <= 1'b0;
      if (ex_done) out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
      state_q <= state_d;
      if (state_q == EX_MUL && mul_cnt_q != 2'd3) mul_cnt_q <= mul_cnt_q + 1'b1;
      else if (state_q != EX_MUL) mul_cnt_q <= '0;
      halted_q <= halted_d;
      pc_q <= pc_d;
    end
  end

  // operand shaping and alu
  always_comb begin
    d_op = ex_item_q.w64 ? ex_d_q : (ex_d_q & MASK32);
    s_raw = ex_item_q.use_src ? ex_s_q : {{32{ex_item_q.imm[31]}}, ex_item_q.imm};
    s_op = ex_item_q.w64 ? s_raw : (s_raw & MASK32);
    sh = ex_item_q.w64 ? s_op[5:0] : {1'b0, s_op[4:0]};
    unique case (ex_item_q.alu)
      A_ADD:  alu_res = d_op + s_op;
      A_SUB:  alu_res = d_op - s_op;
      A_LSH:  alu_res = d_op << sh;
      A_MOV:  alu_res = s_op;
      A_ARSH: alu_res = ex_item_q.w64 ? 64'($signed(d_op) >>> sh) :
                                        {32'd0, 32'($signed(d_op[31:0]) >>> sh[4:0])};
      default: alu_res = acc_q;
    endcase
    if (!ex_item_q.w64) alu_res = alu_res & MASK32;
    unique case (ex_item_q.jcc)
      J_JA:    take = 1'b1;
      J_JEQ:   take = (d_op == s_op);
      J_JGT:   take = (d_op > s_op);
      J_JGE:   take = (d_op >= s_op);
      J_JSET:  take = ((d_op & s_op) != '0);
      J_JNE:   take = (d_op != s_op);
      default: take = 1'b0;
    endcase
    pc_inc = pc_q + 1'b1;
    pc_tgt = pc_q + 1'b1 + ex_item_q.offset[PC_W-1:0];
  end

  // shared 32 by 32 multiplier, one partial product a cycle
  always_comb begin
    mul_x = (mul_cnt_q == 2'd2) ? d_op[63:32] : d_op[31:0];
    mul_y = (mul_cnt_q == 2'd1) ? s_op[63:32] : s_op[31:0];
    prod = 64'(mul_x) * 64'(mul_y);
    acc_d = acc_q;
    if (state_q == EX_MUL) begin
      unique case (mul_cnt_q)
        2'd0:    acc_d = prod;
        2'd1,
        2'd2:    acc_d = acc_q + {prod[31:0], 32'd0};
        default: acc_d = acc_q;
      endcase
    end
  end

  // stack address and store data
  assign addr_base = (ex_item_q.kind == K_LDX) ? ex_s_q : ex_d_q;
  assign mem_addr = addr_base[ADDR_W-1:0] + ex_item_q.offset[ADDR_W-1:0];
  assign st_data = (ex_item_q.kind == K_ST) ? {{32{ex_item_q.imm[31]}}, ex_item_q.imm} : ex_s_q;
  assign nbytes = 4'd1 << ex_item_q.size_log;

  // eight byte banks, each access touches every bank at most once
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [7:0]       bank_mem [ROWS];
    logic [2:0]       lane;
    logic [ROW_W-1:0] row;
    logic             lane_en;

    assign lane = 3'(b) - mem_addr[2:0];
    assign row = mem_addr[ADDR_W-1:3] + ROW_W'(3'(b) < mem_addr[2:0]);
    assign lane_en = ({1'b0, lane} < nbytes);

    always_ff @(posedge clk_i) begin
      if (st_we && lane_en) bank_mem[row] <= st_data[8*lane +: 8];
      if (ld_issue) bank_rdata_q[b] <= bank_mem[row];
    end
  end

  // load data assembly
  always_comb begin
    ld_val = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbytes) ld_val[8*i +: 8] = bank_rdata_q[ld_lo_q + 3'(i)];
    end
  end

  // multi-cycle operations leave the run state
  assign go_load = ex_valid_q && state_q == EX_RUN && ex_item_q.kind == K_LDX && !halted_q;
  assign go_mul = ex_valid_q && state_q == EX_RUN && ex_item_q.kind == K_ALU &&
                  ex_item_q.alu == A_MUL && !halted_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EX_RUN: begin
        if (go_load) state_d = EX_LOAD;
        else if (go_mul) state_d = EX_MUL;
      end
      EX_LOAD, EX_MUL: begin
        if (ex_done) state_d = EX_RUN;
      end
      default: state_d = EX_RUN;
    endcase
  end

  // execute outputs
  always_comb begin
    fin = 1'b0;
    wb_req = 1'b0;
    start_req = 1'b0;
    st_req = 1'b0;
    ld_issue = 1'b0;
    wb_idx = ex_item_q.di;
    wb_val = alu_res;
    halted_d = halted_q;
    pc_d = pc_q;
    res.status = ST_CONTINUE;
    res.next_pc = pc_inc;
    res.helper_id = '0;

    unique case (state_q)
      EX_RUN: begin
        fin = ex_valid_q && !go_load && !go_mul;
        ld_issue = go_load;
        priority if (ex_item_q.kind == K_START) begin
          start_req = 1'b1;
          res.next_pc = '0;
        end else if (halted_q) begin
          res.status = ST_EXIT;
          res.next_pc = pc_q;
        end else begin
          unique case (ex_item_q.kind)
            K_ERR: begin
              res.status = ST_ERROR;
              res.next_pc = pc_q;
            end
            K_EXIT: begin
              res.status = ST_EXIT;
              res.next_pc = pc_q;
            end
            K_ST, K_STX: st_req = 1'b1;
            K_ALU: wb_req = 1'b1;
            K_JMP: res.next_pc = take ? pc_tgt : pc_inc;
            K_CALL: begin
              wb_req = 1'b1;
              wb_idx = REG_RET;
              wb_val = ex_item_q.call_return;
              res.status = ST_HELPER;
              res.helper_id = ex_item_q.imm[7:0];
            end
            default: ;
          endcase
        end
      end
      EX_LOAD: begin
        fin = 1'b1;
        wb_req = 1'b1;
        wb_val = ld_val;
      end
      EX_MUL: begin
        fin = (mul_cnt_q == 2'd3);
        wb_req = 1'b1;
        wb_val = ex_item_q.w64 ? acc_q : (acc_q & MASK32);
      end
      default: ;
    endcase

    ex_done = fin && out_free;
    st_we = st_req && ex_done;
    start_commit = start_req && ex_done;
    rf_we = (wb_req || start_req) && ex_done;
    rf_wa = start_req ? REG_ARG : wb_idx;
    rf_wd = start_req ? initial_arg_i : wb_val;

    // architectural state after this instruction
    if (ex_done) begin
      if (start_req) begin
        halted_d = 1'b0;
        pc_d = '0;
      end else if (!halted_q) begin
        if (res.status == ST_EXIT || res.status == ST_ERROR) halted_d = 1'b1;
        else pc_d = res.next_pc;
      end
    end

    // register values after the step
    if (start_req) begin
      res.dst_value = fwd_value(ex_item_q.di, '0, 1'b1, 1'b0, REG_RET, '0, initial_arg_i);
      res.ret_value = '0;
    end else begin
      res.dst_value = (wb_req && wb_idx == ex_item_q.di) ? wb_val : ex_d_q;
      res.ret_value = (wb_req && wb_idx == REG_RET) ? wb_val : r0_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (rf_wa <= MAX_REG))
    else $error("register file write beyond r10");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EX_LOAD) |-> (ex_valid_q && ex_item_q.kind == K_LDX))
    else $error("load wait without a load in execute");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_commit |=> (!halted_q && pc_q == '0))
    else $error("start did not clear halt and pc");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && ex_done && !start_req) |=> ($stable(pc_q) && halted_q))
    else $error("halted machine changed its pc");

endmodule

[rtl/ebpf_instruction_execute_unit.sv]
// top level of the ebpf instruction execute unit
//
//  channel      direction  handshake                 transaction
//  instruction  in         push_i / full_o           cmd, opcode, indices, offset, imm, call_return
//  result       out        pop_i / empty_o           status, next_pc, dst_value, ret_value, helper_id
//  config       in         psel/penable/pwrite       initial_arg at byte address 0
//
//  one instruction per cycle for alu, jump, store, call, exit and start unless the result register
//  stalls; ldx holds the execute stage in a load wait state (registered stack bank read), mul in a
//  multiply state (shared 32x32 multiplier builds three partial products, then writes back);
//  register reads take one stage ahead; reset clears control state, registers read as zero with r10
//  equal to the stack size; stack bytes hold no reset value
//  a 4-entry queue keeps taking instructions while execute or the result register stalls
module ebpf_instruction_execute_unit import eie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        cmd_i,
  input  logic [7:0]  opcode_i,
  input  logic [3:0]  dst_index_i,
  input  logic [3:0]  src_index_i,
  input  logic [15:0] offset_i,
  input  logic [31:0] imm_i,
  input  logic [63:0] call_return_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  status_o,
  output logic [11:0] next_pc_o,
  output logic [63:0] dst_value_o,
  output logic [63:0] ret_value_o,
  output logic [7:0]  helper_id_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  item_t       front_item, head_item;
  logic        head_valid, head_pop, out_valid;
  result_t     result;
  logic [63:0] initial_arg_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_INITIAL_ARG) ? initial_arg_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_arg_q <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_INITIAL_ARG) begin
      initial_arg_q <= pwdata;
    end
  end

  eie_front u_front (
    .cmd_i         (cmd_i),
    .opcode_i      (opcode_i),
    .dst_index_i   (dst_index_i),
    .src_index_i   (src_index_i),
    .offset_i      (offset_i),
    .imm_i         (imm_i),
    .call_return_i (call_return_i),
    .item_o        (front_item)
  );

  eie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (front_item),
    .full_o  (full_o),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  eie_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (head_pop),
    .initial_arg_i (initial_arg_q),
    .out_valid_o   (out_valid),
    .result_o      (result),
    .out_pop_i     (pop_i)
  );

  // result ports
  assign empty_o = !out_valid;
  assign status_o = result.status;
  assign next_pc_o = result.next_pc;
  assign dst_value_o = result.dst_value;
  assign ret_value_o = result.ret_value;
  assign helper_id_o = result.helper_id;

endmodule

[dv/ebpf_instruction_execute_unit_tb.sv]
// self-checking testbench of the ebpf instruction execute unit
`timescale 1ns / 100ps

module ebpf_instruction_execute_unit_tb;
  import eie_pkg::*;

  localparam int unsigned STACK_SIZE = STACK_BYTES;
  localparam int unsigned SETTLE_CYCLES = 20;

  // one instruction transaction as offered to the block
  typedef struct packed {
    logic        cmd;
    logic [7:0]  opcode;
    logic [3:0]  di;
    logic [3:0]  si;
    logic [15:0] offset;
    logic [31:0] imm;
    logic [63:0] call_return;
  } insn_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic        cmd_i = 1'b0;
  logic [7:0]  opcode_i = '0;
  logic [3:0]  dst_index_i = '0;
  logic [3:0]  src_index_i = '0;
  logic [15:0] offset_i = '0;
  logic [31:0] imm_i = '0;
  logic [63:0] call_return_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [1:0]  status_o;
  logic [11:0] next_pc_o;
  logic [63:0] dst_value_o;
  logic [63:0] ret_value_o;
  logic [7:0]  helper_id_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  ebpf_instruction_execute_unit u_top (.*);

  // clock
  always #4 clk_i = ~clk_i;

  // shadow machine state of the execute unit
  logic [63:0] gpr [NUM_REGS];
  logic [11:0] shadow_pc;
  logic        shadow_halted;
  logic [7:0]  shadow_stack [STACK_SIZE];
  logic        stack_valid [STACK_SIZE];
  logic [63:0] shadow_arg;

  insn_t   pending_insns[$];
  result_t expected_results[$];
  int      send_idle = 0;
  int      recv_idle = 0;
  int      recv_hold = 0;
  int      errors = 0;
  int      status_seen [4];

  function automatic logic [63:0] stack_load(logic [8:0] a, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = shadow_stack[9'(a + i)];
    return v;
  endfunction

  function automatic void stack_store(logic [8:0] a, int n, logic [63:0] v);
    for (int i = 0; i < n; i++) begin
      shadow_stack[9'(a + i)] = v[8*i +: 8];
      stack_valid[9'(a + i)] = 1'b1;
    end
  endfunction

  function automatic int access_bytes(logic [1:0] sz);
    case (sz)
      SZ_W: return 4;
      SZ_H: return 2;
      SZ_B: return 1;
      default: return 8;
    endcase
  endfunction

  // executes one instruction on the shadow state and returns its result
  function automatic result_t execute_insn(insn_t t);
    result_t     r;
    logic [2:0]  cls;
    logic [63:0] imm64, full, d, s, v;
    logic [5:0]  sh;
    logic [11:0] npc;
    logic        take;
    logic [8:0]  a;
    r = '0;
    r.status = ST_CONTINUE;
    cls = t.opcode[2:0];
    imm64 = {{32{t.imm[31]}}, t.imm};
    npc = '0;
    take = 1'b0;
    if (!t.cmd) begin
      for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
      gpr[REG_ARG] = shadow_arg;
      gpr[REG_FP] = 64'(STACK_SIZE);
      shadow_pc = '0;
      shadow_halted = 1'b0;
    end else if (shadow_halted) begin
      r.status = ST_EXIT;
      npc = shadow_pc;
    end else if (t.di > MAX_REG || t.si > MAX_REG) begin
      r.status = ST_ERROR;
    end else if (cls == CLS_LDX || cls == CLS_ST || cls == CLS_STX) begin
      if (t.opcode[7:5] != MODE_MEM) r.status = ST_ERROR;
      else if (cls == CLS_LDX) begin
        a = gpr[t.si][8:0] + t.offset[8:0];
        gpr[t.di] = stack_load(a, access_bytes(t.opcode[4:3]));
      end else begin
        a = gpr[t.di][8:0] + t.offset[8:0];
        stack_store(a, access_bytes(t.opcode[4:3]), cls == CLS_ST ? imm64 : gpr[t.si]);
      end
      npc = shadow_pc + 12'd1;
    end else if (cls == CLS_ALU || cls == CLS_ALU64) begin
      full = (cls == CLS_ALU64) ? '1 : MASK32;
      d = gpr[t.di] & full;
      s = (t.opcode[3] ? gpr[t.si] : imm64) & full;
      sh = (cls == CLS_ALU64) ? s[5:0] : {1'b0, s[4:0]};
      v = '0;
      case (t.opcode[7:4])
        AOP_ADD: v = d + s;
        AOP_SUB: v = d - s;
        AOP_MUL: v = d * s;
        AOP_LSH: v = d << sh;
        AOP_MOV: v = s;
        AOP_ARSH: v = (cls == CLS_ALU64) ? 64'($signed(d) >>> sh)
                                         : {32'b0, 32'($signed(d[31:0]) >>> sh)};
        default: r.status = ST_ERROR;
      endcase
      if (r.status == ST_CONTINUE) gpr[t.di] = v & full;
      npc = shadow_pc + 12'd1;
    end else if (cls == CLS_JMP || cls == CLS_JMP32) begin
      full = (cls == CLS_JMP) ? '1 : MASK32;
      d = gpr[t.di] & full;
      s = (t.opcode[3] ? gpr[t.si] : imm64) & full;
      case (t.opcode[7:4])
        JOP_JA: take = 1'b1;
        JOP_JEQ: take = d == s;
        JOP_JGT: take = d > s;
        JOP_JGE: take = d >= s;
        JOP_JSET: take = (d & s) != 0;
        JOP_JNE: take = d != s;
        JOP_CALL: begin
          gpr[REG_RET] = t.call_return;
          r.status = ST_HELPER;
          r.helper_id = t.imm[7:0];
        end
        JOP_EXIT: r.status = ST_EXIT;
        default: r.status = ST_ERROR;
      endcase
      npc = shadow_pc + 12'd1 + (take ? t.offset[11:0] : 12'd0);
    end else begin
      r.status = ST_ERROR;
    end
    // exit and error stop the program, anything else advances it
    if (t.cmd && !shadow_halted) begin
      if (r.status == ST_EXIT || r.status == ST_ERROR) begin
        shadow_halted = 1'b1;
        npc = shadow_pc;
      end else shadow_pc = npc;
    end
    r.next_pc = npc;
    r.dst_value = (t.di <= MAX_REG) ? gpr[t.di] : '0;
    r.ret_value = gpr[REG_RET];
    return r;
  endfunction

  function automatic void queue_insn(insn_t t);
    pending_insns.push_back(t);
    expected_results.push_back(execute_insn(t));
  endfunction

  function automatic insn_t make_insn(logic cmd, logic [7:0] op, logic [3:0] di,
                                      logic [3:0] si, logic [15:0] off, logic [31:0] imm);
    insn_t t;
    t.cmd = cmd;
    t.opcode = op;
    t.di = di;
    t.si = si;
    t.offset = off;
    t.imm = imm;
    t.call_return = {$urandom, $urandom};
    return t;
  endfunction

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // a well-formed instruction with random content, noise now and then
  function automatic insn_t random_insn();
    insn_t       t;
    logic [3:0]  di, si, aop;
    logic [1:0]  sz;
    logic [8:0]  a;
    int          n;
    bit          found;
    logic [2:0]  cls;
    di = 4'($urandom_range(10));
    si = 4'($urandom_range(10));
    sz = 2'($urandom);
    t = make_insn(1'b1, '0, di, si, 16'($urandom), $urandom);
    if (shadow_halted && $urandom_range(3) != 0) begin
      t.cmd = 1'b0;
      return t;
    end
    if ($urandom_range(19) == 0) t.imm = 32'(pick_wide());
    case ($urandom_range(99)) inside
      [0:2]: t.cmd = 1'b0;
      [3:6]: begin
        t.opcode = 8'($urandom);
        t.di = 4'($urandom);
        t.si = 4'($urandom);
        // a stray load could touch unwritten stack, turn it into a bad index
        if (t.opcode[2:0] == CLS_LDX && t.opcode[7:5] == MODE_MEM)
          t.di = 4'd11 + 4'($urandom_range(4));
      end
      [7:8]: t.si = 4'd11 + 4'($urandom_range(4));
      [9:22]: begin
        n = access_bytes(sz);
        found = 0;
        for (int k = 0; k < 12 && !found; k++) begin
          a = 9'($urandom);
          found = 1;
          for (int i = 0; i < n; i++) if (!stack_valid[9'(a + i)]) found = 0;
        end
        if (found) begin
          t.opcode = {MODE_MEM, sz, CLS_LDX};
          t.offset = {7'($urandom), 9'(a - gpr[si][8:0])};
        end else t.opcode = {MODE_MEM, SZ_DW, CLS_STX};
      end
      [23:34]: t.opcode = {MODE_MEM, sz, CLS_ST};
      [35:46]: t.opcode = {MODE_MEM, sz, CLS_STX};
      [47:74]: begin
        case ($urandom_range(5))
          0: aop = AOP_ADD;
          1: aop = AOP_SUB;
          2: aop = AOP_MUL;
          3: aop = AOP_LSH;
          4: aop = AOP_MOV;
          default: aop = AOP_ARSH;
        endcase
        t.opcode = {aop, 1'($urandom), $urandom_range(1) ? CLS_ALU64 : CLS_ALU};
      end
      [75:92]: begin
        cls = $urandom_range(1) ? CLS_JMP : CLS_JMP32;
        t.opcode = {4'($urandom_range(5)), 1'($urandom), cls};
        if ($urandom_range(3) == 0) t.imm = gpr[di][31:0];
        if ($urandom_range(1)) t.offset = 16'($signed(8'($urandom)));
      end
      [93:97]: begin
        t.opcode = {JOP_CALL, 1'b0, $urandom_range(3) == 0 ? CLS_JMP32 : CLS_JMP};
        t.call_return = pick_wide();
      end
      default: t.opcode = {JOP_EXIT, 1'b0, CLS_JMP};
    endcase
    return t;
  endfunction

  // directed opening: extremes, every operation and the special cases
  task automatic queue_directed();
    queue_insn(make_insn(1'b0, '0, 4'd0, 4'd0, '0, '0));
    queue_insn(make_insn(1'b1, {AOP_MOV, 1'b0, CLS_ALU64}, 4'd2, 4'd0, '0, 32'hFFFF_FFFF));
    queue_insn(make_insn(1'b1, {MODE_MEM, SZ_DW, CLS_ST}, REG_FP, 4'd0, 16'hFFF8,
                         32'h8000_0000));
    // store that wraps past the end of the stack
    queue_insn(make_insn(1'b1, {MODE_MEM, SZ_DW, CLS_STX}, REG_FP, 4'd2, 16'hFFFC, '0));
    queue_insn(make_insn(1'b1, {MODE_MEM, SZ_B, CLS_LDX}, 4'd3, REG_FP, 16'hFFF8, '0));
    queue_insn(make_insn(1'b1, {MODE_MEM, SZ_H, CLS_LDX}, 4'd4, REG_FP, 16'h7FFE, '0));
    queue_insn(make_insn(1'b1, {MODE_MEM, SZ_W, CLS_LDX}, 4'd5, REG_FP, 16'h8000, '0));
    queue_insn(make_insn(1'b1, {MODE_MEM, SZ_DW, CLS_LDX}, 4'd6, REG_FP, 16'hFFFC, '0));
    queue_insn(make_insn(1'b1, {AOP_ADD, 1'b1, CLS_ALU}, 4'd2, 4'd2, '0, '0));
    queue_insn(make_insn(1'b1, {AOP_SUB, 1'b0, CLS_ALU64}, 4'd7, 4'd0, '0, 32'h7FFF_FFFF));
    queue_insn(make_insn(1'b1, {AOP_MUL, 1'b1, CLS_ALU64}, 4'd7, 4'd7, '0, '0));
    queue_insn(make_insn(1'b1, {AOP_LSH, 1'b0, CLS_ALU64}, 4'd6, 4'd0, '0, 32'd127));
    queue_insn(make_insn(1'b1, {AOP_ARSH, 1'b0, CLS_ALU}, 4'd5, 4'd0, '0, 32'd63));
    queue_insn(make_insn(1'b1, {AOP_ARSH, 1'b1, CLS_ALU64}, 4'd7, 4'd1, '0, '0));
    // taken jumps that wrap the program counter both ways
    queue_insn(make_insn(1'b1, {JOP_JA, 1'b0, CLS_JMP}, 4'd0, 4'd0, 16'h8000, '0));
    queue_insn(make_insn(1'b1, {JOP_JEQ, 1'b0, CLS_JMP32}, 4'd2, 4'd0, 16'h7FFF, 32'hFFFF_FFFF));
    queue_insn(make_insn(1'b1, {JOP_JGT, 1'b1, CLS_JMP}, 4'd7, 4'd1, 16'hFFFF, '0));
    queue_insn(make_insn(1'b1, {JOP_JGE, 1'b0, CLS_JMP}, 4'd1, 4'd0, 16'd3, '0));
    queue_insn(make_insn(1'b1, {JOP_JSET, 1'b1, CLS_JMP}, 4'd2, 4'd2, 16'd2, '0));
    queue_insn(make_insn(1'b1, {JOP_JNE, 1'b0, CLS_JMP32}, 4'd3, 4'd0, 16'd5, '0));
    queue_insn(make_insn(1'b1, {JOP_CALL, 1'b0, CLS_JMP}, 4'd0, 4'd0, '0, 32'h0000_01FF));
    // register index past r10, then an instruction while halted
    queue_insn(make_insn(1'b1, {AOP_ADD, 1'b0, CLS_ALU64}, 4'd15, 4'd0, '0, '0));
    queue_insn(make_insn(1'b1, {AOP_ADD, 1'b0, CLS_ALU64}, 4'd1, 4'd0, '0, '0));
    queue_insn(make_insn(1'b0, '0, 4'd0, 4'd0, '0, '0));
    queue_insn(make_insn(1'b1, {JOP_EXIT, 1'b0, CLS_JMP}, 4'd0, 4'd0, '0, '0));
  endtask

  // instruction driver
  always @(posedge clk_i) begin
    if (push_i && !full_o) void'(pending_insns.pop_front());
    if (pending_insns.size() > 0 && $urandom_range(99) >= send_idle && rst_ni) begin
      push_i <= 1'b1;
      {cmd_i, opcode_i, dst_index_i, src_index_i, offset_i, imm_i, call_return_i}
        <= pending_insns[0];
    end else push_i <= 1'b0;
  end

  // long hold-off of the result side
  always @(posedge clk_i) begin
    if (recv_hold > 0) recv_hold <= recv_hold - 1;
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (pop_i && !empty_o) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        status_seen[status_o]++;
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          errors++;
        end
        if (next_pc_o !== exp_r.next_pc) begin
          $error("next_pc expected %0d actual %0d", exp_r.next_pc, next_pc_o);
          errors++;
        end
        if (dst_value_o !== exp_r.dst_value) begin
          $error("dst_value expected %h actual %h", exp_r.dst_value, dst_value_o);
          errors++;
        end
        if (ret_value_o !== exp_r.ret_value) begin
          $error("ret_value expected %h actual %h", exp_r.ret_value, ret_value_o);
          errors++;
        end
        if (helper_id_o !== exp_r.helper_id) begin
          $error("helper_id expected %h actual %h", exp_r.helper_id, helper_id_o);
          errors++;
        end
      end
    end
    pop_i <= rst_ni && recv_hold == 0 && $urandom_range(99) >= recv_idle;
  end

  // configuration write followed by a read back
  task automatic write_initial_arg(logic [63:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_INITIAL_ARG;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    shadow_arg = v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) begin
      $error("initial_arg read back expected %h actual %h", v, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (pending_insns.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // run limit
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // reset, then phases of configuration and stimulus
  initial begin
    int          idle_mix [5][2];
    logic [63:0] arg;
    idle_mix = '{'{0, 0}, '{78, 0}, '{0, 78}, '{31, 31}, '{0, 0}};
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
    gpr[REG_FP] = 64'(STACK_SIZE);
    shadow_pc = '0;
    shadow_halted = 1'b0;
    shadow_arg = '0;
    for (int i = 0; i < STACK_SIZE; i++) stack_valid[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: arg = '0;
        1: arg = '1;
        2: arg = 64'h8000_0000_0000_0000;
        default: arg = {$urandom, $urandom};
      endcase
      write_initial_arg(arg);
      @(negedge clk_i);
      send_idle = idle_mix[ph][0];
      recv_idle = idle_mix[ph][1];
      if (ph == 4) recv_hold = 300;
      if (ph == 0) queue_directed();
      queue_insn(make_insn(1'b0, '0, 4'd0, 4'd0, '0, '0));
      for (int k = 0; k < 245; k++) queue_insn(random_insn());
      drain();
    end
    $display("checked %0d continue, %0d exit, %0d helper and %0d error results",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("over five idle mixes and initial_arg settings incl. a full-stall stretch");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/eie_pkg.sv
rtl/eie_front.sv
rtl/eie_queue.sv
rtl/eie_back.sv
rtl/ebpf_instruction_execute_unit.sv
dv/ebpf_instruction_execute_unit_tb.sv
